FILE: hw/rtl/tmgp_pkg.sv
// Shared types and register indexes for the trimmed mean gain and phase block.
`timescale 1ns / 1ps
`default_nettype none
package tmgp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MV_W       = 20;

  localparam logic [CFG_IDX_W-1:0] REG_MV_PER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_CENTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DB_PER_MV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_ZERO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_MV   = 3'd4;

  // Command from the sequencer to a channel engine.
  typedef struct packed {
    logic start;
    logic last;
  } tmgp_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tmgp_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tmgp_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/tmgp_chan.sv
// One channel: sorted insert into RAM, trimmed sum, divide and millivolt scaling.
`timescale 1ns / 1ps
`default_nettype none
module tmgp_chan #(
  parameter int BURST_LEN     = 16,
  parameter int TRIM_EACH_END = 4,
  parameter int SAMPLE_BITS   = 14
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire tmgp_pkg::tmgp_cmd_t            cmd_i,
  input  wire logic [SAMPLE_BITS-1:0]         sample_i,
  input  wire logic [$clog2(BURST_LEN)-1:0]   fill_i,
  input  wire logic [tmgp_pkg::CFG_DATA_W-1:0] mv_per_count_i,
  output logic                                done_o,
  output logic [tmgp_pkg::MV_W-1:0]           mv_o
);

  localparam int ADDR_W = $clog2(BURST_LEN);
  localparam int TRIM   = (2 * TRIM_EACH_END >= BURST_LEN) ? (BURST_LEN - 1) / 2
                                                          : TRIM_EACH_END;
  localparam int KEPT   = BURST_LEN - 2 * TRIM;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(KEPT + 1);
  localparam int PW     = SAMPLE_BITS + tmgp_pkg::CFG_DATA_W;
  // The sum is divided by multiplying with ceil(2^RSH / KEPT); with RSH set to
  // the sum width plus ceil(log2(KEPT)) the floor is exact for every sum.
  localparam int RSH     = SUM_W + $clog2(KEPT);
  localparam int RECIP_W = RSH + 1;
  localparam int QP_W    = SUM_W + RECIP_W;
  localparam longint RECIP = ((longint'(1) << RSH) + longint'(KEPT) - 1) / longint'(KEPT);
  localparam logic [RECIP_W-1:0] RECIP_C   = RECIP_W'(RECIP);
  localparam logic [ADDR_W-1:0]  FIRST_IDX = ADDR_W'(TRIM);
  localparam logic [ADDR_W-1:0]  LAST_IDX  = ADDR_W'(BURST_LEN - TRIM - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CMP, ST_SUM, ST_SUMW, ST_DIV, ST_MUL, ST_SAT
  } state_e;

  state_e                   state_q;
  logic [SAMPLE_BITS-1:0]   val_q;
  logic [ADDR_W-1:0]        k_q;
  logic                     last_q;
  logic [ADDR_W-1:0]        j_q;
  logic                     rv_q;
  logic [SUM_W-1:0]         acc_q;
  logic [SUM_W-1:0]         sum_q;
  logic [QP_W-1:0]          qprod_q;
  logic [PW-1:0]            prod_q;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_addr;
  logic [SAMPLE_BITS-1:0]   ram_wdata;
  logic [SAMPLE_BITS-1:0]   ram_rdata;
  logic [SUM_W-1:0]         acc_next;

  tmgp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(BURST_LEN)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign acc_next = acc_q + SUM_W'(ram_rdata);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = k_q;
    ram_wdata = val_q;
    case (state_q)
      ST_RD: begin
        if (k_q == '0) begin
          ram_we = 1'b1;
        end else begin
          ram_addr = k_q - 1'b1;
        end
      end
      ST_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata > val_q) begin
          ram_wdata = ram_rdata;
        end
      end
      ST_SUM:  ram_addr = j_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_o  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_i.start) begin
            val_q   <= sample_i;
            k_q     <= fill_i;
            last_q  <= cmd_i.last;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          if (k_q == '0) begin
            if (last_q) begin
              j_q     <= FIRST_IDX;
              acc_q   <= '0;
              rv_q    <= 1'b0;
              state_q <= ST_SUM;
            end else begin
              done_o  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end else begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (ram_rdata > val_q) begin
            k_q     <= k_q - 1'b1;
            state_q <= ST_RD;
          end else if (last_q) begin
            j_q     <= FIRST_IDX;
            acc_q   <= '0;
            rv_q    <= 1'b0;
            state_q <= ST_SUM;
          end else begin
            done_o  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_SUM: begin
          // Read data is registered, so it arrives in the cycle after its address.
          rv_q <= 1'b1;
          if (rv_q) begin
            acc_q <= acc_next;
          end
          j_q <= j_q + 1'b1;
          if (j_q == LAST_IDX) begin
            state_q <= ST_SUMW;
          end
        end
        ST_SUMW: begin
          sum_q   <= acc_next;
          rv_q    <= 1'b0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          qprod_q <= QP_W'(sum_q) * QP_W'(RECIP_C);
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= PW'(qprod_q[RSH +: SAMPLE_BITS]) * PW'(mv_per_count_i);
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          mv_o    <= (prod_q[PW-1:tmgp_pkg::MV_W+8] != '0) ? '1
                                                            : prod_q[tmgp_pkg::MV_W+7:8];
          done_o  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/trimmed_mean_gain_phase_top.sv
// Top level of the trimmed mean gain and phase block.
//
// Input channel (in_valid_i/in_ready_o) carries one magnitude and one phase
// converter count per transfer. Each count is inserted into its own sorted
// RAM by a read-compare-write loop on the single RAM port, moving larger
// entries up until a compare stops it or it reaches the bottom entry. The
// block takes no new transfer until both channels have finished the item.
// The BURST_LEN-th transfer of a burst also sums the kept entries, divides
// by the kept count with a reciprocal multiply, scales to millivolts and
// maps to gain and phase. Its result appears on the output channel
// (out_valid_o/out_ready_i); other items give no result.
// The output register holds a result while the receiver stalls; new items are
// still taken meanwhile, and only a finished burst waits for the register.
// Reset clears the fill count, control state and output valid, and sets the configuration registers to defaults.
// Configuration writes (cfg_we_i) take effect at once and belong to idle time.
`timescale 1ns / 1ps
`default_nettype none
module trimmed_mean_gain_phase_top #(
  parameter int BURST_LEN     = 16,
  parameter int TRIM_EACH_END = 4,
  parameter int SAMPLE_BITS   = 14
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tmgp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tmgp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [13:0]                       mag_sample_i,
  input  wire logic [13:0]                       phase_sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [19:0]                            mag_mv_q8_o,
  output logic [19:0]                            phase_mv_q8_o,
  output logic signed [15:0]                     gain_db_q8_o,
  output logic signed [16:0]                     phase_deg_q8_o
);

  localparam int ADDR_W = $clog2(BURST_LEN);
  localparam logic [ADDR_W-1:0] LAST_FILL = ADDR_W'(BURST_LEN - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_MUL, ST_OUT} state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   fill_q;
  logic                last_q;
  logic                mag_done_q, phs_done_q;
  logic [23:0]         mv_per_count_q, db_per_mv_q, deg_per_mv_q;
  logic [19:0]         mag_center_q, phase_zero_q;
  logic signed [45:0]  gain_prod_q, phase_prod_q;
  logic [19:0]         mag_mv_q, phs_mv_q;

  tmgp_pkg::tmgp_cmd_t cmd;
  logic                in_xfer;
  logic                mag_done, phs_done;
  logic [19:0]         mag_mv, phs_mv;
  logic signed [20:0]  gain_diff, phase_diff;
  logic signed [29:0]  gain_fl, phase_fl;
  logic signed [15:0]  gain_sat;
  logic signed [16:0]  phase_sat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cmd.start  = in_xfer;
  assign cmd.last   = (fill_q == LAST_FILL);

  tmgp_chan #(.BURST_LEN(BURST_LEN), .TRIM_EACH_END(TRIM_EACH_END),
              .SAMPLE_BITS(SAMPLE_BITS)) u_mag (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_i      (SAMPLE_BITS'(mag_sample_i)),
    .fill_i        (fill_q),
    .mv_per_count_i(mv_per_count_q),
    .done_o        (mag_done),
    .mv_o          (mag_mv)
  );

  tmgp_chan #(.BURST_LEN(BURST_LEN), .TRIM_EACH_END(TRIM_EACH_END),
              .SAMPLE_BITS(SAMPLE_BITS)) u_phase (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_i      (SAMPLE_BITS'(phase_sample_i)),
    .fill_i        (fill_q),
    .mv_per_count_i(mv_per_count_q),
    .done_o        (phs_done),
    .mv_o          (phs_mv)
  );

  assign gain_diff  = $signed({1'b0, mag_mv_q}) - $signed({1'b0, mag_center_q});
  assign phase_diff = $signed({1'b0, phase_zero_q}) - $signed({1'b0, phs_mv_q});
  assign gain_fl    = gain_prod_q[45:16];
  assign phase_fl   = phase_prod_q[45:16];

  always_comb begin
    if (gain_fl > 30'sd32767) begin
      gain_sat = 16'sh7FFF;
    end else if (gain_fl < -30'sd32768) begin
      gain_sat = -16'sd32768;
    end else begin
      gain_sat = gain_fl[15:0];
    end
    if (phase_fl > 30'sd65535) begin
      phase_sat = 17'sh0FFFF;
    end else if (phase_fl < -30'sd65536) begin
      phase_sat = -17'sd65536;
    end else begin
      phase_sat = phase_fl[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_per_count_q <= 24'd9601;
      mag_center_q   <= 20'd230400;
      db_per_mv_q    <= 24'd2185;
      phase_zero_q   <= 20'd460800;
      deg_per_mv_q   <= 24'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmgp_pkg::REG_MV_PER_COUNT: mv_per_count_q <= cfg_wdata_i;
        tmgp_pkg::REG_MAG_CENTER:   mag_center_q   <= cfg_wdata_i[19:0];
        tmgp_pkg::REG_DB_PER_MV:    db_per_mv_q    <= cfg_wdata_i;
        tmgp_pkg::REG_PHASE_ZERO:   phase_zero_q   <= cfg_wdata_i[19:0];
        tmgp_pkg::REG_DEG_PER_MV:   deg_per_mv_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      last_q      <= 1'b0;
      mag_done_q  <= 1'b0;
      phs_done_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      // The output step reloads the register itself when it frees up.
      if (out_valid_o && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            last_q     <= cmd.last;
            fill_q     <= cmd.last ? '0 : fill_q + 1'b1;
            mag_done_q <= 1'b0;
            phs_done_q <= 1'b0;
            state_q    <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (mag_done) begin
            mag_done_q <= 1'b1;
            mag_mv_q   <= mag_mv;
          end
          if (phs_done) begin
            phs_done_q <= 1'b1;
            phs_mv_q   <= phs_mv;
          end
          if ((mag_done || mag_done_q) && (phs_done || phs_done_q)) begin
            state_q <= last_q ? ST_MUL : ST_IDLE;
          end
        end
        ST_MUL: begin
          gain_prod_q  <= gain_diff * $signed({1'b0, db_per_mv_q});
          phase_prod_q <= phase_diff * $signed({1'b0, deg_per_mv_q});
          state_q      <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o    <= 1'b1;
            mag_mv_q8_o    <= mag_mv_q;
            phase_mv_q8_o  <= phs_mv_q;
            gain_db_q8_o   <= gain_sat;
            phase_deg_q8_o <= phase_sat;
            state_q        <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mag_done || phs_done) |-> (state_q == ST_RUN))
    else $error("channel finished outside of a running item");

  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result appeared without the output step");

  a_last_clears_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && cmd.last) |=> (fill_q == '0) && last_q)
    else $error("burst end did not restart the fill count");

endmodule
`default_nettype wire
